/* rtl/core/quadratic_probe_hash_table_macros.svh */
// Assertion helpers shared by the table RTL.
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define QPHT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qpht assertion failed");

// Common form: block clock and reset.
`define QPHT_ASSERT(lbl, prop) `QPHT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* rtl/core/qpht_pkg.sv */
package qpht_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;

  // request opcodes; the fourth code is a no-op that reports not found
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_e;

endpackage

/* rtl/core/qpht_ram.sv */
module qpht_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/qpht_home.sv */
// Home slot: key mod TableSlots. Mask for a power of two, otherwise
// four key bits per cycle through restoring reduction.
module qpht_home import qpht_pkg::*; #(
  parameter int unsigned TableSlots = TABLE_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [KEY_W-1:0]              key_i,
  output logic                          done_o,
  output logic [$clog2(TableSlots)-1:0] home_o
);

  localparam int unsigned AW = $clog2(TableSlots);

  if ((TableSlots & (TableSlots - 1)) == 0) begin : g_pow2
    logic          done_q;
    logic [AW-1:0] home_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        home_q <= key_i[AW-1:0];
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end else begin : g_serial
    localparam int unsigned NIB  = (KEY_W + 3) / 4;
    localparam int unsigned SH_W = NIB * 4;
    localparam int unsigned NCW  = (NIB > 1) ? $clog2(NIB) : 1;
    localparam logic [AW:0] SlotsW  = (AW+1)'(TableSlots);
    localparam logic [NCW-1:0] LastNib = NCW'(NIB - 1);

    logic            busy_q, done_q;
    logic [NCW-1:0]  nib_cnt_q;
    logic [SH_W-1:0] sh_q;
    logic [AW-1:0]   rem_q, rem_d;

    always_comb begin
      logic [AW-1:0] r;
      logic [AW:0]   t;
      logic [3:0]    nib;
      nib = sh_q[SH_W-1 -: 4];
      r   = rem_q;
      for (int b = 3; b >= 0; b--) begin
        t = {r, nib[b]};
        if (t >= SlotsW) begin
          t = t - SlotsW;
        end
        r = t[AW-1:0];
      end
      rem_d = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q    <= 1'b0;
        done_q    <= 1'b0;
        nib_cnt_q <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q    <= 1'b1;
          nib_cnt_q <= '0;
        end else if (busy_q) begin
          nib_cnt_q <= nib_cnt_q + 1'b1;
          if (nib_cnt_q == LastNib) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= SH_W'(key_i);
        rem_q <= '0;
      end else if (busy_q) begin
        sh_q  <= {sh_q[SH_W-5:0], 4'b0000};
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign home_o = rem_q;
  end

endmodule

/* rtl/core/quadratic_probe_hash_table.sv */
// A request passes the home-slot step, then the probe walk until a probe decides;
//   the home step is a serial key mod when TableSlots is not a power of two.
// Throughput: one request at a time, next accept the cycle after the result is
//   latched; one probe per cycle.
// Reset: a clearing pass zeroes the flag memory; stall is held high until it
//   ends. Key/value memory is not cleared.
module quadratic_probe_hash_table import qpht_pkg::*; #(
  parameter int unsigned TableSlots = TABLE_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [KEY_W-1:0]    req_key_i,
  input  logic [VALUE_W-1:0]  req_value_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [VALUE_W-1:0]  found_value_o,
  output logic                table_empty_o
);

`include "quadratic_probe_hash_table_macros.svh"

  localparam int unsigned AW = $clog2(TableSlots);
  localparam int unsigned CW = $clog2(TableSlots + 1);
  localparam int unsigned DW = KEY_W + VALUE_W;
  localparam logic [AW:0]   SlotsW   = (AW+1)'(TableSlots);
  localparam logic [CW-1:0] SlotsCnt = CW'(TableSlots);
  localparam logic [CW-1:0] LastCnt  = CW'(TableSlots - 1);
  localparam logic [AW-1:0] LastIdx  = AW'(TableSlots - 1);

  // flag memory word: {occupied, tombstone}
  localparam logic [1:0] FLG_CLEAR = 2'b00;
  localparam logic [1:0] FLG_OCC   = 2'b10;
  localparam logic [1:0] FLG_TOMB  = 2'b01;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  // request held for the whole probe walk
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // probe walk: slot advances by successive odd numbers (i*i increments)
  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] odd_q, odd_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic [AW-1:0] pend_slot_q, pend_slot_d;
  logic          issue;
  logic [AW:0]   slot_sum, odd_sum;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;

  status_e            res_status_q, res_status_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  found_value_q;
  logic                table_empty_q;
  logic                out_load;

  logic                in_accept;
  logic                home_start, home_done;
  logic [AW-1:0]       home_slot;

  // memory ports
  logic          dat_we;
  logic [DW-1:0] dat_rd;
  logic          flg_we;
  logic [AW-1:0] flg_waddr;
  logic [1:0]    flg_wdata, flg_rd;

  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_value;
  logic               rd_occ, rd_tomb, key_eq;

  // probe decision
  logic    dec_done, dec_ins, dec_rem;
  status_e dec_status;
  logic [VALUE_W-1:0] dec_value;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign home_start = in_accept && (op_i == OP_INSERT || op_i == OP_SEARCH ||
                                    op_i == OP_REMOVE);

  qpht_home #(
    .TableSlots(TableSlots)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(home_start),
    .key_i  (req_key_i),
    .done_o (home_done),
    .home_o (home_slot)
  );

  // key/value store: written on insert or update, no reset
  qpht_ram #(
    .Depth(TableSlots),
    .Width(DW)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dat_we),
    .waddr_i(pend_slot_q),
    .wdata_i({key_q, value_q}),
    .raddr_i(slot_q),
    .rdata_o(dat_rd)
  );

  // occupied/tombstone store, swept to zero after reset
  qpht_ram #(
    .Depth(TableSlots),
    .Width(2)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flg_we),
    .waddr_i(flg_waddr),
    .wdata_i(flg_wdata),
    .raddr_i(slot_q),
    .rdata_o(flg_rd)
  );

  assign rd_key   = dat_rd[DW-1:VALUE_W];
  assign rd_value = dat_rd[VALUE_W-1:0];
  assign rd_occ   = flg_rd[1];
  assign rd_tomb  = flg_rd[0];
  // key bits of an unoccupied slot may be stale; only used when occupied
  assign key_eq   = (rd_key == key_q);

  // Check the probe whose read data is back. Insert updates a matching key or takes
  // the first free slot (empty or tombstone); search/remove end at a never-used slot.
  always_comb begin
    dec_done   = 1'b0;
    dec_ins    = 1'b0;
    dec_rem    = 1'b0;
    dat_we     = 1'b0;
    dec_status = ST_NOT_FOUND;
    dec_value  = '0;
    if (state_q == S_PROBE && pend_q) begin
      if (op_q == OP_INSERT) begin
        if (!rd_occ) begin
          dec_done   = 1'b1;
          dec_ins    = 1'b1;
          dat_we     = 1'b1;
          dec_status = ST_INSERTED;
        end else if (key_eq) begin
          dec_done   = 1'b1;
          dat_we     = 1'b1;
          dec_status = ST_UPDATED;
        end else if (pend_last_q) begin
          dec_done   = 1'b1;
          dec_status = ST_FULL;
        end
      end else begin
        if (!rd_occ && !rd_tomb) begin
          dec_done   = 1'b1;
          dec_status = ST_NOT_FOUND;
        end else if (rd_occ && key_eq) begin
          dec_done = 1'b1;
          if (op_q == OP_REMOVE) begin
            dec_rem    = 1'b1;
            dec_status = ST_REMOVED;
          end else begin
            dec_status = ST_FOUND;
            dec_value  = rd_value;
          end
        end else if (pend_last_q) begin
          dec_done   = 1'b1;
          dec_status = ST_NOT_FOUND;
        end
      end
    end
  end

  always_comb begin
    flg_we    = 1'b0;
    flg_waddr = pend_slot_q;
    flg_wdata = FLG_CLEAR;
    if (state_q == S_CLEAR) begin
      flg_we    = 1'b1;
      flg_waddr = clr_idx_q;
    end else if (dec_ins) begin
      flg_we    = 1'b1;
      flg_wdata = FLG_OCC;
    end else if (dec_rem) begin
      flg_we    = 1'b1;
      flg_wdata = FLG_TOMB;
    end
  end

  // next probe address: slot + (2i+1), both reduced mod TableSlots
  assign issue    = (iss_q != SlotsCnt);
  assign slot_sum = {1'b0, slot_q} + {1'b0, odd_q};
  assign odd_sum  = {1'b0, odd_q} + (AW+1)'(2);

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    odd_d        = odd_q;
    iss_d        = iss_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    pend_slot_d  = pend_slot_q;
    count_d      = count_q;
    clr_idx_d    = clr_idx_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      S_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (home_start) begin
            state_d = S_HOME;
          end else begin
            // unused opcode: no change, reports not found
            res_status_d = ST_NOT_FOUND;
            res_value_d  = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_HOME: begin
        if (home_done) begin
          slot_d  = home_slot;
          odd_d   = AW'(1);
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        pend_d = issue;
        if (issue) begin
          slot_d      = (slot_sum >= SlotsW) ? AW'(slot_sum - SlotsW) : slot_sum[AW-1:0];
          odd_d       = (odd_sum >= SlotsW) ? AW'(odd_sum - SlotsW) : odd_sum[AW-1:0];
          iss_d       = iss_q + 1'b1;
          pend_last_d = (iss_q == LastCnt);
          pend_slot_d = slot_q;
        end
        if (dec_done) begin
          res_status_d = dec_status;
          res_value_d  = dec_value;
          state_d      = S_DONE;
          if (dec_ins) begin
            count_d = count_q + 1'b1;
          end else if (dec_rem && count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
    slot_q       <= slot_d;
    odd_q        <= odd_d;
    pend_slot_q  <= pend_slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      status_q      <= res_status_q;
      found_value_q <= res_value_q;
      table_empty_q <= (count_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_value_q;
  assign table_empty_o = table_empty_q;

  `QPHT_ASSERT(a_count_bound, count_q <= SlotsCnt)
  `QPHT_ASSERT(a_busy_after_accept, in_accept |=> in_stall_o)
  `QPHT_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q) == S_DONE)
  `QPHT_ASSERT(a_insert_not_empty, (out_valid_q && status_q == ST_INSERTED) |-> !table_empty_q)

endmodule
